// ===== sv/modbus_register_map_access_assert.svh =====
// Assertion macros for the register map block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef MODBUS_REGISTER_MAP_ACCESS_ASSERT_SVH
`define MODBUS_REGISTER_MAP_ACCESS_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MRMA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled during reset
`define MRMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== sv/mrma_pkg.sv =====
// Shared types, codes and constants of the register map block.
// No dependencies.
`default_nettype none

package mrma_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] KIND_8  = 2'd0;
	localparam logic [1:0] KIND_16 = 2'd1;
	localparam logic [1:0] KIND_32 = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_ADDR   = 2'd1;
	localparam logic [1:0] STAT_ACCESS = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] access_addr;
		logic [15:0] write_value;
		logic [3:0]  entry_index;
		logic [15:0] entry_start;
		logic [1:0]  entry_kind;
		logic        entry_read_only;
		logic [31:0] entry_init;
	} in_req_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic [1:0]  status;
	} out_rsp_t;

	typedef struct packed {
		logic [15:0] start;
		logic [1:0]  kind;
		logic        read_only;
	} map_ent_t;

	typedef struct packed {
		logic hit;
		logic second;
	} match_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DATA,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== sv/mrma_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mrma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/mrma_match.sv =====
// Address compare unit: tests one map entry against a register address.
// Depends on mrma_pkg.
`default_nettype none

module mrma_match (
	input  wire logic [15:0]        access_addr,
	input  wire mrma_pkg::map_ent_t ent,
	output mrma_pkg::match_t        result
);

	logic [16:0] next_addr;

	// 17 bits so that a 32-bit entry at the top address never wraps
	assign next_addr = {1'b0, ent.start} + 17'd1;

	always_comb begin
		result.hit    = 1'b0;
		result.second = 1'b0;
		case (ent.kind) inside
			mrma_pkg::KIND_8, mrma_pkg::KIND_16: begin
				result.hit = (access_addr == ent.start);
			end
			mrma_pkg::KIND_32: begin
				if (access_addr == ent.start) begin
					result.hit = 1'b1;
				end else if ({1'b0, access_addr} == next_addr) begin
					result.hit    = 1'b1;
					result.second = 1'b1;
				end
			end
			default: begin
				result.hit = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/modbus_register_map_access.sv =====
// Modbus holding register map: loads, reads and writes of mapped variables.
// An access with no entries in use, or op 3, goes from ST_IDLE to ST_FIN; a load passes
// through ST_LOAD, a hit through ST_SCAN and ST_DATA, a miss through ST_SCAN over all n =
// min(entries_in_use, MAX_ENTRIES) entries, scanned one per cycle through one compare unit.
// One request at a time; a stalled result holds input.
// Reset clears the sequencer, out_valid and entries_in_use; tables are undefined until loaded.
`default_nettype none

module modbus_register_map_access #(
	parameter int MAX_ENTRIES = mrma_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [4:0]        cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire mrma_pkg::in_req_t in_req,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output mrma_pkg::out_rsp_t     out_rsp
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int MAP_W = $bits(mrma_pkg::map_ent_t);

	mrma_pkg::state_t   state_q, state_d;
	mrma_pkg::in_req_t  req_q;
	mrma_pkg::out_rsp_t res_q, res_d, out_q;
	mrma_pkg::map_ent_t map_rd, map_wr, hit_ent_q;
	mrma_pkg::match_t   match;

	logic [4:0]       eiu_q;
	logic [CNT_W-1:0] n_c, iss_q;
	logic             pend_q, hit_second_q, out_valid_q;
	logic [IDX_W-1:0] pend_idx_q, hit_idx_q, ld_idx;
	logic             accept, res_we, out_load, load_bad;

	logic             map_we, data_we;
	logic [IDX_W-1:0] map_waddr, map_raddr, data_waddr, data_raddr;
	logic [31:0]      data_wdata, data_rd, init_val;

	assign accept = in_valid && !in_stall;
	assign ld_idx = IDX_W'(req_q.entry_index);
	assign load_bad = (int'(req_q.entry_index) >= MAX_ENTRIES);

	always_comb begin
		if (int'(eiu_q) > MAX_ENTRIES) begin
			n_c = CNT_W'(MAX_ENTRIES);
		end else begin
			n_c = CNT_W'(eiu_q);
		end
	end

	mrma_ram #(
		.WIDTH(MAP_W),
		.DEPTH(MAX_ENTRIES),
		.AW   (IDX_W)
	) u_map_ram (
		.clk    (clk),
		.wr_en  (map_we),
		.wr_addr(map_waddr),
		.wr_data(map_wr),
		.rd_addr(map_raddr),
		.rd_data(map_rd)
	);

	mrma_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ENTRIES),
		.AW   (IDX_W)
	) u_data_ram (
		.clk    (clk),
		.wr_en  (data_we),
		.wr_addr(data_waddr),
		.wr_data(data_wdata),
		.rd_addr(data_raddr),
		.rd_data(data_rd)
	);

	mrma_match u_match (
		.access_addr(req_q.access_addr),
		.ent        (map_rd),
		.result     (match)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrma_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_req.op) inside
						mrma_pkg::OP_READ, mrma_pkg::OP_WRITE: begin
							state_d = (n_c == '0) ? mrma_pkg::ST_FIN : mrma_pkg::ST_SCAN;
						end
						mrma_pkg::OP_LOAD: state_d = mrma_pkg::ST_LOAD;
						default:           state_d = mrma_pkg::ST_FIN;
					endcase
				end
			end
			mrma_pkg::ST_LOAD: state_d = mrma_pkg::ST_FIN;
			mrma_pkg::ST_SCAN: begin
				if (pend_q && match.hit) begin
					state_d = mrma_pkg::ST_DATA;
				end else if (!pend_q && iss_q >= n_c) begin
					state_d = mrma_pkg::ST_FIN;
				end
			end
			mrma_pkg::ST_DATA: state_d = mrma_pkg::ST_FIN;
			mrma_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = mrma_pkg::ST_IDLE;
				end
			end
			default: state_d = mrma_pkg::ST_IDLE;
		endcase
	end

	// Outputs and datapath controls
	always_comb begin
		in_stall   = 1'b1;
		map_we     = 1'b0;
		map_waddr  = ld_idx;
		map_wr     = '{start: req_q.entry_start, kind: req_q.entry_kind,
			read_only: req_q.entry_read_only};
		map_raddr  = iss_q[IDX_W-1:0];
		data_we    = 1'b0;
		data_waddr = ld_idx;
		data_raddr = hit_idx_q;
		res_we     = 1'b0;
		res_d      = '{read_value: 16'd0, status: mrma_pkg::STAT_OK};
		out_load   = 1'b0;

		case (req_q.entry_kind)
			mrma_pkg::KIND_8:  init_val = {24'd0, req_q.entry_init[7:0]};
			mrma_pkg::KIND_16: init_val = {16'd0, req_q.entry_init[15:0]};
			default:           init_val = req_q.entry_init;
		endcase
		data_wdata = init_val;

		unique case (state_q)
			mrma_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (accept) begin
					res_we = 1'b1;
					if ((in_req.op == mrma_pkg::OP_READ || in_req.op == mrma_pkg::OP_WRITE)
						&& n_c == '0) begin
						res_d.status = mrma_pkg::STAT_ADDR;
					end
				end
			end
			mrma_pkg::ST_LOAD: begin
				res_we = 1'b1;
				if (load_bad) begin
					res_d.status = mrma_pkg::STAT_ADDR;
				end else begin
					map_we  = 1'b1;
					data_we = 1'b1;
				end
			end
			mrma_pkg::ST_SCAN: begin
				// Fetch the data word of the entry under compare in parallel
				data_raddr = pend_idx_q;
				if (!(pend_q && match.hit) && !pend_q && iss_q >= n_c) begin
					res_we       = 1'b1;
					res_d.status = mrma_pkg::STAT_ADDR;
				end
			end
			mrma_pkg::ST_DATA: begin
				res_we     = 1'b1;
				data_waddr = hit_idx_q;
				if (req_q.op == mrma_pkg::OP_READ) begin
					case (hit_ent_q.kind)
						mrma_pkg::KIND_8:  res_d.read_value = {8'd0, data_rd[7:0]};
						mrma_pkg::KIND_16: res_d.read_value = data_rd[15:0];
						default: begin
							res_d.read_value = hit_second_q ? data_rd[15:0] : data_rd[31:16];
						end
					endcase
				end else if (hit_ent_q.read_only) begin
					res_d.status = mrma_pkg::STAT_ACCESS;
				end else begin
					data_we = 1'b1;
					case (hit_ent_q.kind)
						mrma_pkg::KIND_8:  data_wdata = {24'd0, req_q.write_value[7:0]};
						mrma_pkg::KIND_16: data_wdata = {16'd0, req_q.write_value};
						default: begin
							if (hit_second_q) begin
								data_wdata = {data_rd[31:16], req_q.write_value};
							end else begin
								data_wdata = {req_q.write_value, data_rd[15:0]};
							end
						end
					endcase
				end
			end
			mrma_pkg::ST_FIN: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrma_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			eiu_q       <= 5'd0;
			iss_q       <= '0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				eiu_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				iss_q  <= '0;
				pend_q <= 1'b0;
			end else if (state_q == mrma_pkg::ST_SCAN) begin
				// Advance the issue pointer until every entry in use is fetched
				if (iss_q < n_c) begin
					iss_q  <= iss_q + CNT_W'(1);
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
		end
		if (res_we) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
		if (state_q == mrma_pkg::ST_SCAN) begin
			pend_idx_q <= iss_q[IDX_W-1:0];
			if (pend_q && match.hit) begin
				hit_idx_q    <= pend_idx_q;
				hit_ent_q    <= map_rd;
				hit_second_q <= match.second;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	`include "modbus_register_map_access_assert.svh"

	`MRMA_ASSERT_NEXT(a_one_at_a_time, accept, in_stall, "request accepted while busy")
	`MRMA_ASSERT_NOW(a_access_only_write,
		(state_q == mrma_pkg::ST_FIN) && (res_q.status == mrma_pkg::STAT_ACCESS),
		req_q.op == mrma_pkg::OP_WRITE, "access error on a non-write request")
	`MRMA_ASSERT_NOW(a_value_only_read,
		(state_q == mrma_pkg::ST_FIN) && (res_q.read_value != 16'd0),
		req_q.op == mrma_pkg::OP_READ, "read value on a non-read request")
	`MRMA_ASSERT_NOW(a_scan_bound, state_q == mrma_pkg::ST_SCAN, iss_q <= n_c,
		"scan ran past the entries in use")

endmodule

`default_nettype wire
